/* design/jsu_pkg.sv */
// Shared types and constants for the JSON string unescape block.
// No dependencies; imported by jsu_decode and json_string_unescape.
package jsu_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_DONE     = 2'd1,
    ST_NO_QUOTE = 2'd2,
    ST_UNTERM   = 2'd3
  } status_t;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    phase_t      phase;
    logic [1:0]  hex_count;
    logic [11:0] hex_acc;
  } jsu_state_t;

  // Results caused by one input byte; entries past count are don't-care.
  typedef struct packed {
    logic [1:0]                    count;
    logic [MAX_RESULTS-1:0][7:0]   bytes;
    logic                          has_byte;
    status_t                       status;
  } jsu_result_t;

endpackage

/* design/jsu_decode.sv */
// Combinational decode step: current parser state plus one input byte
// gives the next state and up to three result bytes. Depends on jsu_pkg.
module jsu_decode (
  input  jsu_pkg::jsu_state_t  cur,
  input  logic [7:0]           ch,
  input  logic                 start_req,
  input  logic                 end_of_text,
  output jsu_pkg::jsu_state_t  nxt,
  output jsu_pkg::jsu_result_t res
);
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam jsu_state_t IDLE_STATE = '{phase: PH_IDLE, hex_count: 2'd0, hex_acc: 12'd0};

  logic        hex_ok;
  logic [3:0]  hex_digit;
  logic [15:0] cp;

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      hex_digit = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      hex_digit = ch[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp = {cur.hex_acc, hex_digit};

  always_comb begin
    nxt          = cur;
    res.count    = 2'd1;
    res.bytes    = '0;
    res.has_byte = 1'b0;
    res.status   = ST_DATA;

    if (start_req) begin
      nxt = IDLE_STATE;
      if (end_of_text || ch != CH_QUOTE) begin
        res.status = ST_NO_QUOTE;
      end else begin
        nxt.phase = PH_BODY;
      end
    end else if (cur.phase != PH_BODY && cur.phase != PH_ESC && cur.phase != PH_HEX) begin
      nxt = IDLE_STATE;
    end else if (end_of_text) begin
      nxt        = IDLE_STATE;
      res.status = ST_UNTERM;
    end else begin
      unique case (cur.phase)
        PH_BODY: begin
          if (ch == CH_QUOTE) begin
            nxt        = IDLE_STATE;
            res.status = ST_DONE;
          end else if (ch == CH_BSLASH) begin
            nxt.phase = PH_ESC;
          end else begin
            res.bytes[0] = ch;
            res.has_byte = 1'b1;
          end
        end
        PH_ESC: begin
          nxt.phase    = PH_BODY;
          res.has_byte = 1'b1;
          unique case (ch)
            CH_B:    res.bytes[0] = 8'h08;
            CH_F:    res.bytes[0] = 8'h0c;
            CH_N:    res.bytes[0] = 8'h0a;
            CH_R:    res.bytes[0] = 8'h0d;
            CH_T:    res.bytes[0] = 8'h09;
            CH_U: begin
              nxt          = '{phase: PH_HEX, hex_count: 2'd0, hex_acc: 12'd0};
              res.has_byte = 1'b0;
            end
            default: res.bytes[0] = ch;
          endcase
        end
        default: begin
          // hex digits of a \u escape
          if (!hex_ok) begin
            nxt        = IDLE_STATE;
            res.status = ST_UNTERM;
          end else if (cur.hex_count != 2'd3) begin
            nxt.hex_acc   = {cur.hex_acc[7:0], hex_digit};
            nxt.hex_count = cur.hex_count + 2'd1;
          end else begin
            nxt          = '{phase: PH_BODY, hex_count: 2'd0, hex_acc: 12'd0};
            res.has_byte = 1'b1;
            if (cp[15:7] == 9'd0) begin
              res.bytes[0] = cp[7:0];
            end else if (cp[15:11] == 5'd0) begin
              res.count    = 2'd2;
              res.bytes[0] = {3'b110, cp[10:6]};
              res.bytes[1] = {2'b10, cp[5:0]};
            end else begin
              res.count    = 2'd3;
              res.bytes[0] = {4'b1110, cp[15:12]};
              res.bytes[1] = {2'b10, cp[11:6]};
              res.bytes[2] = {2'b10, cp[5:0]};
            end
          end
        end
      endcase
    end
  end

endmodule

/* design/json_string_unescape.sv */
// Top level of the JSON string unescape block: parser state, output
// register and stream handshakes. Depends on jsu_pkg and jsu_decode.
//
// Feed one byte of a JSON string literal per transfer, with tuser[0] set on
// the opening quote; every input transfer yields one or more output
// transfers, the final one marked by tlast. Bytes that decode to nothing
// still yield one transfer with has_byte low that carries the status
// (0 data, 1 complete, 2 no opening quote, 3 unterminated or bad \u digit).
// Throughput is one input byte per cycle while m_tready stays high; a \u
// escape whose code point needs two or three UTF-8 bytes holds the single
// output register until its last byte goes, and a new input is taken in
// that cycle. The first output is offered in the cycle after the input.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] ch
  input  logic [1:0] s_tuser,   // [0] start_req, [1] end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [0] has_byte, [2:1] status
  output logic       m_tlast
);
  import jsu_pkg::*;

  jsu_state_t  state;
  jsu_state_t  state_next;
  jsu_result_t res;

  logic                        ovalid;
  logic [1:0]                  oidx;
  logic [1:0]                  ocount;
  logic [MAX_RESULTS-1:0][7:0] obytes;
  logic                        ohas;
  status_t                     ostat;

  logic in_fire;
  logic out_fire;

  jsu_decode u_decode (
    .cur         (state),
    .ch          (s_tdata),
    .start_req   (s_tuser[0]),
    .end_of_text (s_tuser[1]),
    .nxt         (state_next),
    .res         (res)
  );

  assign m_tvalid = ovalid;
  assign m_tlast  = (oidx == ocount - 2'd1);
  assign m_tdata  = obytes[oidx];
  assign m_tuser  = {ostat, ohas};

  // Take a new byte while the register is empty or its final transfer leaves.
  assign s_tready = !ovalid || (m_tready && m_tlast);
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = ovalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '{phase: PH_IDLE, hex_count: 2'd0, hex_acc: 12'd0};
      ovalid <= 1'b0;
      oidx   <= 2'd0;
    end else begin
      if (in_fire) begin
        state  <= state_next;
        ovalid <= 1'b1;
        oidx   <= 2'd0;
      end else if (out_fire) begin
        if (m_tlast) begin
          ovalid <= 1'b0;
        end else begin
          oidx <= oidx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ocount <= res.count;
      obytes <= res.bytes;
      ohas   <= res.has_byte;
      ostat  <= res.status;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (oidx < ocount))
    else $error("output index past result count");

  a_multi_is_data: assert property (@(posedge clk) disable iff (rst)
    (ovalid && ocount != 2'd1) |-> (ohas && ostat == ST_DATA))
    else $error("multi-byte result without data flags");

  a_load_starts_at_first: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (m_tvalid && oidx == 2'd0))
    else $error("accepted byte did not load the output register");

  a_hex_clear_outside: assert property (@(posedge clk) disable iff (rst)
    (state.phase != PH_HEX) |-> (state.hex_count == 2'd0 && state.hex_acc == 12'd0))
    else $error("hex accumulator live outside hex phase");

endmodule

/* tb/sv/json_string_unescape_tb.sv */
// Self-checking bench for json_string_unescape: drives JSON string literals
// byte by byte and compares every output transfer against a local decoder.
// Depends on jsu_pkg and the json_string_unescape RTL.
`timescale 1ns / 100ps

module json_string_unescape_tb;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] ESC_B     = 8'h62;
  localparam logic [7:0] ESC_F     = 8'h66;
  localparam logic [7:0] ESC_N     = 8'h6e;
  localparam logic [7:0] ESC_R     = 8'h72;
  localparam logic [7:0] ESC_T     = 8'h74;
  localparam logic [7:0] ESC_U     = 8'h75;
  localparam logic [7:0] CTL_BS    = 8'h08;
  localparam logic [7:0] CTL_FF    = 8'h0c;
  localparam logic [7:0] CTL_LF    = 8'h0a;
  localparam logic [7:0] CTL_CR    = 8'h0d;
  localparam logic [7:0] CTL_TAB   = 8'h09;
  localparam int unsigned SRC_ITEMS = 460;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    status_t    status;
    logic       last;
  } dec_result_t;

  class unescape_board;
    phase_t        phase;
    logic [1:0]    hex_count;
    logic [11:0]   hex_acc;
    dec_result_t   pending_out[$];
    int            mismatches;
    int            checked;

    function new();
      go_idle();
      mismatches = 0;
      checked = 0;
    endfunction

    // Returns {valid, value} for one ASCII hex digit.
    static function logic [4:0] hex_nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
    endfunction

    function void go_idle();
      phase = PH_IDLE;
      hex_count = '0;
      hex_acc = '0;
    endfunction

    function void push_out(logic [7:0] b, logic has, status_t st, logic lst);
      dec_result_t r;
      r.out_byte = b;
      r.has_byte = has;
      r.status = st;
      r.last = lst;
      pending_out.push_back(r);
    endfunction

    // Queue the output transfers caused by one source byte; returns 1 when
    // the byte falls on an idle decoder and is dropped.
    function bit note_source_byte(logic [7:0] ch, logic start, logic eot);
      logic [4:0]  nib;
      logic [15:0] cp;
      logic [7:0]  mapped;
      if (start) begin
        go_idle();
        if (eot || ch != CH_QUOTE) begin
          push_out(8'h00, 1'b0, ST_NO_QUOTE, 1'b1);
        end else begin
          phase = PH_BODY;
          push_out(8'h00, 1'b0, ST_DATA, 1'b1);
        end
        return 1'b0;
      end
      if (phase == PH_IDLE) begin
        push_out(8'h00, 1'b0, ST_DATA, 1'b1);
        return 1'b1;
      end
      if (eot) begin
        go_idle();
        push_out(8'h00, 1'b0, ST_UNTERM, 1'b1);
        return 1'b0;
      end
      case (phase)
        PH_BODY: begin
          if (ch == CH_QUOTE) begin
            go_idle();
            push_out(8'h00, 1'b0, ST_DONE, 1'b1);
          end else if (ch == CH_BSLASH) begin
            phase = PH_ESC;
            push_out(8'h00, 1'b0, ST_DATA, 1'b1);
          end else begin
            push_out(ch, 1'b1, ST_DATA, 1'b1);
          end
        end
        PH_ESC: begin
          if (ch == ESC_U) begin
            phase = PH_HEX;
            hex_count = '0;
            hex_acc = '0;
            push_out(8'h00, 1'b0, ST_DATA, 1'b1);
          end else begin
            case (ch)
              ESC_B:   mapped = CTL_BS;
              ESC_F:   mapped = CTL_FF;
              ESC_N:   mapped = CTL_LF;
              ESC_R:   mapped = CTL_CR;
              ESC_T:   mapped = CTL_TAB;
              default: mapped = ch;
            endcase
            phase = PH_BODY;
            push_out(mapped, 1'b1, ST_DATA, 1'b1);
          end
        end
        default: begin
          nib = hex_nibble(ch);
          if (!nib[4]) begin
            go_idle();
            push_out(8'h00, 1'b0, ST_UNTERM, 1'b1);
          end else if (hex_count != 2'd3) begin
            hex_acc = {hex_acc[7:0], nib[3:0]};
            hex_count = hex_count + 2'd1;
            push_out(8'h00, 1'b0, ST_DATA, 1'b1);
          end else begin
            // Fourth digit: encode the code point as UTF-8.
            cp = {hex_acc, nib[3:0]};
            phase = PH_BODY;
            hex_count = '0;
            hex_acc = '0;
            if (cp < 16'h0080) begin
              push_out(cp[7:0], 1'b1, ST_DATA, 1'b1);
            end else if (cp < 16'h0800) begin
              push_out(8'hc0 | {3'b000, cp[10:6]}, 1'b1, ST_DATA, 1'b0);
              push_out(8'h80 | {2'b00, cp[5:0]}, 1'b1, ST_DATA, 1'b1);
            end else begin
              push_out(8'he0 | {4'h0, cp[15:12]}, 1'b1, ST_DATA, 1'b0);
              push_out(8'h80 | {2'b00, cp[11:6]}, 1'b1, ST_DATA, 1'b0);
              push_out(8'h80 | {2'b00, cp[5:0]}, 1'b1, ST_DATA, 1'b1);
            end
          end
        end
      endcase
      return 1'b0;
    endfunction

    function void check_decoded(logic [7:0] b, logic has, logic [1:0] st, logic lst);
      dec_result_t want;
      checked++;
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected transfer byte %02h has %0d status %0d last %0d",
                   $time, b, has, st, lst);
        return;
      end
      want = pending_out.pop_front();
      if (want.out_byte !== b || want.has_byte !== has || want.status !== st ||
          want.last !== lst) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected byte %02h has %0d status %0d last %0d, got %02h %0d %0d %0d",
                   $time, want.out_byte, want.has_byte, want.status, want.last,
                   b, has, st, lst);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic [1:0] s_tuser;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  unescape_board board;
  bit            gaps_on;
  int            decoded_items;
  int            strings_sent;

  json_string_unescape u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("json_string_unescape_tb NOT OK");
    $finish;
  end

  // Hold the byte until the transfer, then record it.
  task automatic send_item(input logic [7:0] ch, input logic start, input logic eot);
    while (gaps_on && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= {eot, start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!board.note_source_byte(ch, start, eot)) decoded_items++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] nib;
    c = 8'($urandom_range(0, 255));
    nib = unescape_board::hex_nibble(c);
    while (nib[4]) begin
      c = 8'($urandom_range(0, 255));
      nib = unescape_board::hex_nibble(c);
    end
    return c;
  endfunction

  function automatic logic [7:0] escape_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0: c = ESC_B;
      1: c = ESC_F;
      2: c = ESC_N;
      3: c = ESC_R;
      4: c = ESC_T;
      5: c = CH_QUOTE;
      6: c = CH_BSLASH;
      7: c = CH_SLASH;
      default: begin
        c = 8'($urandom_range(0, 255));
        if (c == ESC_U) c = 8'h71;
      end
    endcase
    return c;
  endfunction

  function automatic logic [15:0] random_code_point();
    logic [15:0] corners[6];
    corners = '{16'h0000, 16'h007f, 16'h0080, 16'h07ff, 16'h0800, 16'hffff};
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 16'h007f));
      1: return 16'($urandom_range(16'h0080, 16'h07ff));
      2: return 16'($urandom_range(16'h0800, 16'hffff));
      3: return corners[$urandom_range(0, 5)];
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  task automatic send_hex(input logic [15:0] cp);
    send_item(CH_BSLASH, 1'b0, 1'b0);
    send_item(ESC_U, 1'b0, 1'b0);
    for (int i = 3; i >= 0; i--) send_item(hex_char(cp[i*4 +: 4]), 1'b0, 1'b0);
  endtask

  task automatic send_partial_hex();
    send_item(CH_BSLASH, 1'b0, 1'b0);
    send_item(ESC_U, 1'b0, 1'b0);
    repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom_range(0, 15))), 1'b0, 1'b0);
  endtask

  // One literal with random content; most close properly, the rest end broken or trail bytes after the close.
  task automatic send_random_string();
    logic [7:0] c;
    int         pick;
    strings_sent++;
    send_item(CH_QUOTE, 1'b1, 1'b0);
    repeat ($urandom_range(0, 10)) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(0, 255));
        send_item(c, 1'b0, 1'b0);
      end else if (pick < 7) begin
        send_item(CH_BSLASH, 1'b0, 1'b0);
        send_item(escape_char(), 1'b0, 1'b0);
      end else begin
        send_hex(random_code_point());
      end
    end
    case ($urandom_range(0, 19))
      14: send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      15: begin
        send_partial_hex();
        send_item(non_hex_char(), 1'b0, 1'b0);
      end
      16: begin
        send_item(CH_BSLASH, 1'b0, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      17: begin
        send_partial_hex();
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      18: begin
        // Restart without an opening quote.
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE) c = ~c;
        send_item(c, 1'b1, 1'($urandom_range(0, 1)));
      end
      19: begin
        send_item(CH_QUOTE, 1'b0, 1'b0);
        repeat ($urandom_range(1, 3))
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end
      default: send_item(CH_QUOTE, 1'b0, 1'b0);
    endcase
  endtask

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        board.check_decoded(m_tdata, m_tuser[0], m_tuser[2:1], m_tlast);
      m_tready <= gaps_on ? ($urandom_range(99) >= 29) : 1'b1;
    end
  end

  initial begin
    board = new();
    gaps_on = 1'b1;
    decoded_items = 0;
    strings_sent = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    s_tuser <= 2'b00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle drops, missing quote, byte extremes, escapes, UTF-8 width,
    // bad hex digit, end of text inside an escape, empty string.
    send_item(8'h78, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(CH_QUOTE, 1'b1, 1'b1);
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(CH_BSLASH, 1'b0, 1'b0);
    send_item(ESC_T, 1'b0, 1'b0);
    send_hex(16'hffff);
    send_item(CH_BSLASH, 1'b0, 1'b0);
    send_item(ESC_U, 1'b0, 1'b0);
    send_item(8'h30, 1'b0, 1'b0);
    send_item(8'h67, 1'b0, 1'b0);
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(CH_BSLASH, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(CH_QUOTE, 1'b1, 1'b0);
    send_item(CH_QUOTE, 1'b0, 1'b0);

    decoded_items = 0;
    while (decoded_items < SRC_ITEMS) begin
      // Run a stretch with both sides streaming back to back.
      gaps_on = !(decoded_items >= 180 && decoded_items < 280);
      send_random_string();
    end
    gaps_on = 1'b1;
    s_tvalid <= 1'b0;

    while (board.pending_out.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Decoded %0d random source bytes across %0d literals after the directed cases.",
             decoded_items, strings_sent);
    $display("Checked %0d output transfers, %0d mismatches.", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("json_string_unescape_tb OK");
    end else begin
      $display("json_string_unescape_tb NOT OK");
    end
    $finish;
  end

endmodule
